FILE: rtl/phet_pkg.sv
// Shared types and constants for the priority event hook table.
// Used by every module of the block except phet_ram; depends on nothing.
`default_nettype none

package phet_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int CAP_W = 6;
	localparam int CODE_W = 16;

	typedef enum logic [1:0] {
		FUNC_REGISTER = 2'd0,
		FUNC_DISPATCH = 2'd1,
		FUNC_ENABLE = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [CODE_W-1:0] event_code;
		logic [CODE_W-1:0] owner_id;
		logic signed [CODE_W-1:0] priority_req;
		logic enable_flag;
		logic [CAP_W-1:0] max_handlers;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic has_handler;
		logic [CODE_W-1:0] handler_out;
		logic [CAP_W-1:0] dispatch_count;
		logic [CAP_W-1:0] entries_used;
		logic last;
	} out_item_t;

	// one hook as stored in the table memory
	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic [CODE_W-1:0] owner_id;
		logic signed [CODE_W-1:0] prio;
		logic enabled;
	} entry_t;

	// one dispatch candidate in the sort memory
	typedef struct packed {
		logic signed [CODE_W-1:0] prio;
		logic [CODE_W-1:0] owner_id;
	} pick_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REG,
		ST_SCAN,
		ST_SORT_LOAD,
		ST_SORT_CUR,
		ST_SORT_SCAN,
		ST_SORT_STORE,
		ST_EMIT_INIT,
		ST_EMIT_RD,
		ST_EMIT_PUSH,
		ST_RESP
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_REG,
		CMD_SCAN,
		CMD_SORT_LOAD,
		CMD_SORT_CUR,
		CMD_SORT_SCAN,
		CMD_SORT_STORE,
		CMD_EMIT_INIT,
		CMD_EMIT_RD,
		CMD_EMIT_PUSH,
		CMD_RESP
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic scan_done;
		logic cnt_ge2;
		logic pass_end;
		logic next_pass;
		logic n_zero;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/phet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module phet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/phet_ctrl.sv
// Controller state machine of the hook table: sequences register, enable,
// dispatch scan, exchange sort and result emission. Depends on phet_pkg.
`default_nettype none

module phet_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire phet_pkg::status_t  sts,
	output phet_pkg::cmd_t          cmd
);

	phet_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = phet_pkg::CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			phet_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = phet_pkg::CMD_ACCEPT;
					state_d = phet_pkg::ST_DECODE;
				end
			end
			phet_pkg::ST_DECODE: begin
				case (sts.func) inside
					phet_pkg::FUNC_REGISTER: state_d = phet_pkg::ST_REG;
					phet_pkg::FUNC_DISPATCH, phet_pkg::FUNC_ENABLE: state_d = phet_pkg::ST_SCAN;
					default: state_d = phet_pkg::ST_RESP;
				endcase
			end
			phet_pkg::ST_REG: begin
				cmd = phet_pkg::CMD_REG;
				state_d = phet_pkg::ST_RESP;
			end
			phet_pkg::ST_SCAN: begin
				cmd = phet_pkg::CMD_SCAN;
				if (sts.scan_done) begin
					if (sts.func != phet_pkg::FUNC_DISPATCH) begin
						state_d = phet_pkg::ST_RESP;
					end else if (sts.cnt_ge2) begin
						state_d = phet_pkg::ST_SORT_LOAD;
					end else begin
						state_d = phet_pkg::ST_EMIT_INIT;
					end
				end
			end
			phet_pkg::ST_SORT_LOAD: begin
				cmd = phet_pkg::CMD_SORT_LOAD;
				state_d = phet_pkg::ST_SORT_CUR;
			end
			phet_pkg::ST_SORT_CUR: begin
				cmd = phet_pkg::CMD_SORT_CUR;
				state_d = phet_pkg::ST_SORT_SCAN;
			end
			phet_pkg::ST_SORT_SCAN: begin
				cmd = phet_pkg::CMD_SORT_SCAN;
				if (sts.pass_end) begin
					state_d = phet_pkg::ST_SORT_STORE;
				end
			end
			phet_pkg::ST_SORT_STORE: begin
				cmd = phet_pkg::CMD_SORT_STORE;
				state_d = sts.next_pass ? phet_pkg::ST_SORT_LOAD : phet_pkg::ST_EMIT_INIT;
			end
			phet_pkg::ST_EMIT_INIT: begin
				cmd = phet_pkg::CMD_EMIT_INIT;
				state_d = sts.n_zero ? phet_pkg::ST_RESP : phet_pkg::ST_EMIT_RD;
			end
			phet_pkg::ST_EMIT_RD: begin
				cmd = phet_pkg::CMD_EMIT_RD;
				state_d = phet_pkg::ST_EMIT_PUSH;
			end
			phet_pkg::ST_EMIT_PUSH: begin
				if (sts.out_free) begin
					cmd = phet_pkg::CMD_EMIT_PUSH;
					state_d = sts.emit_last ? phet_pkg::ST_IDLE : phet_pkg::ST_EMIT_RD;
				end
			end
			phet_pkg::ST_RESP: begin
				if (sts.out_free) begin
					cmd = phet_pkg::CMD_RESP;
					state_d = phet_pkg::ST_IDLE;
				end
			end
			default: state_d = phet_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/phet_dp.sv
// Datapath of the hook table: hook and candidate memories, scan and sort
// counters, output register. Depends on phet_pkg and phet_ram.
`default_nettype none

module phet_dp #(
	parameter int TABLE_DEPTH = phet_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire phet_pkg::in_item_t  in_item,
	input  wire phet_pkg::cmd_t      cmd,
	output phet_pkg::status_t        sts,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output phet_pkg::out_item_t      out_item
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	phet_pkg::in_item_t req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] a_q;
	logic [AW-1:0] addr_s1;
	logic vld_s1;
	logic st_q;
	phet_pkg::pick_t cur_q;
	logic [phet_pkg::CAP_W-1:0] n_q;
	logic [phet_pkg::CAP_W-1:0] e_q;
	phet_pkg::out_item_t out_q;
	logic out_valid_q;

	logic tab_we, tab_re, pk_we, pk_re;
	logic [AW-1:0] tab_waddr, tab_raddr, pk_waddr, pk_raddr;
	phet_pkg::entry_t tab_wdata, tab_rd;
	phet_pkg::pick_t pk_wdata, pk_rd;

	logic full, out_free, issue, load, swap, hid_hit, ev_hit;
	logic [6:0] cnt_w, cap_w, min_w, n_w;

	phet_ram #(.WIDTH($bits(phet_pkg::entry_t)), .DEPTH(TABLE_DEPTH)) u_tab_ram (
		.clk     (clk),
		.wr_en   (tab_we),
		.wr_addr (tab_waddr),
		.wr_data (tab_wdata),
		.rd_en   (tab_re),
		.rd_addr (tab_raddr),
		.rd_data (tab_rd)
	);

	phet_ram #(.WIDTH($bits(phet_pkg::pick_t)), .DEPTH(TABLE_DEPTH)) u_pick_ram (
		.clk     (clk),
		.wr_en   (pk_we),
		.wr_addr (pk_waddr),
		.wr_data (pk_wdata),
		.rd_en   (pk_re),
		.rd_addr (pk_raddr),
		.rd_data (pk_rd)
	);

	assign full = (count_q == CW'(TABLE_DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign load = (cmd == phet_pkg::CMD_EMIT_PUSH) || (cmd == phet_pkg::CMD_RESP);
	assign hid_hit = (tab_rd.owner_id == req_q.owner_id);
	assign ev_hit = tab_rd.enabled && (tab_rd.event_code == req_q.event_code);
	assign swap = vld_s1 && (pk_rd.prio > cur_q.prio);

	// scan issue: table reads during ST_SCAN, candidate reads during a sort pass
	always_comb begin
		issue = 1'b0;
		if (cmd == phet_pkg::CMD_SCAN) begin
			issue = (idx_q < count_q);
		end else if (cmd == phet_pkg::CMD_SORT_SCAN) begin
			issue = (idx_q < cnt_q);
		end
	end

	// result count: min of candidates, cap and the result limit
	always_comb begin
		cnt_w = 7'(cnt_q);
		cap_w = 7'(req_q.max_handlers);
		min_w = (cnt_w < cap_w) ? cnt_w : cap_w;
		n_w = (min_w > 7'(phet_pkg::RESULT_LIMIT)) ? 7'(phet_pkg::RESULT_LIMIT) : min_w;
	end

	always_comb begin
		tab_we = 1'b0;
		tab_waddr = count_q[AW-1:0];
		tab_wdata = '{event_code: req_q.event_code, owner_id: req_q.owner_id,
			prio: req_q.priority_req, enabled: 1'b1};
		tab_re = (cmd == phet_pkg::CMD_SCAN) && issue;
		tab_raddr = idx_q[AW-1:0];
		pk_we = 1'b0;
		pk_waddr = cnt_q[AW-1:0];
		pk_wdata = '{prio: tab_rd.prio, owner_id: tab_rd.owner_id};
		pk_re = 1'b0;
		pk_raddr = idx_q[AW-1:0];
		case (cmd)
			phet_pkg::CMD_REG: tab_we = !full;
			phet_pkg::CMD_SCAN: begin
				if (vld_s1 && req_q.func == phet_pkg::FUNC_ENABLE && hid_hit) begin
					tab_we = 1'b1;
					tab_waddr = addr_s1;
					tab_wdata = tab_rd;
					tab_wdata.enabled = req_q.enable_flag;
				end
				pk_we = vld_s1 && req_q.func == phet_pkg::FUNC_DISPATCH && ev_hit;
			end
			phet_pkg::CMD_SORT_LOAD: begin
				pk_re = 1'b1;
				pk_raddr = a_q[AW-1:0];
			end
			phet_pkg::CMD_SORT_SCAN: begin
				pk_re = issue;
				// push the displaced current head back into the slot just read
				pk_we = swap;
				pk_waddr = addr_s1;
				pk_wdata = cur_q;
			end
			phet_pkg::CMD_SORT_STORE: begin
				pk_we = 1'b1;
				pk_waddr = a_q[AW-1:0];
				pk_wdata = cur_q;
			end
			phet_pkg::CMD_EMIT_RD: begin
				pk_re = 1'b1;
				pk_raddr = AW'(e_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			a_q <= '0;
			vld_s1 <= 1'b0;
			st_q <= 1'b0;
			e_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd == phet_pkg::CMD_SCAN || cmd == phet_pkg::CMD_SORT_SCAN) begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			case (cmd)
				phet_pkg::CMD_ACCEPT: begin
					cnt_q <= '0;
					idx_q <= '0;
					a_q <= '0;
					vld_s1 <= 1'b0;
					st_q <= 1'b0;
				end
				phet_pkg::CMD_REG: begin
					if (full) begin
						st_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				phet_pkg::CMD_SCAN: begin
					if (pk_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				phet_pkg::CMD_SORT_CUR: begin
					idx_q <= a_q + CW'(1);
					vld_s1 <= 1'b0;
				end
				phet_pkg::CMD_SORT_STORE: a_q <= a_q + CW'(1);
				phet_pkg::CMD_EMIT_INIT: e_q <= '0;
				phet_pkg::CMD_EMIT_PUSH: e_q <= e_q + 6'd1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd == phet_pkg::CMD_ACCEPT) begin
			req_q <= in_item;
		end
		if (issue) begin
			addr_s1 <= idx_q[AW-1:0];
		end
		if (cmd == phet_pkg::CMD_SORT_CUR) begin
			cur_q <= pk_rd;
		end else if (cmd == phet_pkg::CMD_SORT_SCAN && swap) begin
			cur_q <= pk_rd;
		end
		if (cmd == phet_pkg::CMD_EMIT_INIT) begin
			n_q <= 6'(n_w);
		end
		if (cmd == phet_pkg::CMD_EMIT_PUSH) begin
			out_q <= '{status: 1'b0, has_handler: 1'b1, handler_out: pk_rd.owner_id,
				dispatch_count: n_q, entries_used: 6'(count_q), last: sts.emit_last};
		end else if (cmd == phet_pkg::CMD_RESP) begin
			out_q <= '{status: st_q, has_handler: 1'b0, handler_out: '0,
				dispatch_count: '0, entries_used: 6'(count_q), last: 1'b1};
		end
	end

	always_comb begin
		sts.func = req_q.func;
		sts.scan_done = (idx_q == count_q) && !vld_s1;
		sts.cnt_ge2 = ((CW+1)'(cnt_q) >= (CW+1)'(2));
		sts.pass_end = (idx_q == cnt_q) && vld_s1;
		sts.next_pass = ((CW+1)'(a_q) + (CW+1)'(2)) < (CW+1)'(cnt_q);
		sts.n_zero = (n_w == 7'd0);
		sts.out_free = out_free;
		sts.emit_last = ((7'(e_q) + 7'd1) == 7'(n_q));
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_reg_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == phet_pkg::CMD_REG && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("register did not append a hook");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("output register overwritten while a result waits");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= count_q)
		else $error("candidate count exceeds hook count");

	a_swap_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == phet_pkg::CMD_SORT_SCAN && swap) |=> (cur_q == $past(pk_rd)))
		else $error("sort head not replaced by higher priority candidate");

endmodule

`default_nettype wire

FILE: rtl/priority_event_hook_table_top.sv
// Top level of the priority event hook table: controller plus datapath.
// Depends on phet_pkg, phet_ctrl, phet_dp (and phet_ram through phet_dp).
//
// Usage: one input channel (in_valid/in_ready/in_item) carries operations:
// register a hook, dispatch an event, or set the enable flag of a handler.
// One output channel (out_valid/out_ready/out_item) gives the results:
// one item per register, enable or unused code, one item per dispatched
// handler id (last set on the final one), or one empty item for a dispatch
// that selects nothing. in_ready is high only while the block is idle; one
// operation is in work at a time, and a finished result may wait in the
// output register while the next item is taken.
// Enable and dispatch scan all N registered hooks through the single read
// port of the hook memory; a dispatch with C matching candidates then runs
// the exchange sort on the candidate memory when C is 2 or more, sets up
// emission and reads the candidate memory once per id emitted.
// A stalled receiver holds the result in the output register and pauses
// emission. Reset clears the hook count and control state; the memories
// keep no reset value and need no clearing pass.
`default_nettype none

module priority_event_hook_table_top #(
	parameter int TABLE_DEPTH = phet_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire phet_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output phet_pkg::out_item_t      out_item
);

	phet_pkg::cmd_t cmd;
	phet_pkg::status_t sts;

	phet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	phet_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

FILE: dv/hook_table_checker.sv
// Result checker for the priority event hook table: keeps its own hook table,
// predicts the result items of every accepted input item and compares them in order.
// Depends on phet_pkg.
module hook_table_checker
	import phet_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	output int        fail_count,
	output int        pending,
	output int        results_checked,
	output int        longest_dispatch
);

	logic [CODE_W-1:0]        hook_code  [TABLE_DEPTH];
	logic [CODE_W-1:0]        hook_owner [TABLE_DEPTH];
	logic signed [CODE_W-1:0] hook_prio  [TABLE_DEPTH];
	logic                     hook_on    [TABLE_DEPTH];
	int                       hook_used;
	out_item_t                due_q[$];
	out_item_t                want;

	initial begin
		fail_count = 0;
		pending = 0;
		results_checked = 0;
		longest_dispatch = 0;
		hook_used = 0;
	end

	task automatic apply_item(input in_item_t it);
		int        order [TABLE_DEPTH];
		int        n_match;
		int        n_ids;
		int        tmp;
		out_item_t r;
		n_match = 0;
		r = '0;
		r.last = 1'b1;
		case (it.func)
		FUNC_REGISTER: begin
			if (hook_used >= TABLE_DEPTH) begin
				r.status = 1'b1;
			end else begin
				hook_code[hook_used] = it.event_code;
				hook_owner[hook_used] = it.owner_id;
				hook_prio[hook_used] = it.priority_req;
				hook_on[hook_used] = 1'b1;
				hook_used++;
			end
		end
		FUNC_ENABLE: begin
			for (int i = 0; i < hook_used; i++) begin
				if (hook_owner[i] == it.owner_id)
					hook_on[i] = it.enable_flag;
			end
		end
		FUNC_DISPATCH: begin
			for (int i = 0; i < hook_used; i++) begin
				if (hook_on[i] && hook_code[i] == it.event_code) begin
					order[n_match] = i;
					n_match++;
				end
			end
			// a later hook with strictly higher priority swaps forward
			for (int a = 0; a < n_match; a++) begin
				for (int b = a + 1; b < n_match; b++) begin
					if (hook_prio[order[b]] > hook_prio[order[a]]) begin
						tmp = order[a];
						order[a] = order[b];
						order[b] = tmp;
					end
				end
			end
			n_ids = n_match;
			if (int'(it.max_handlers) < n_ids)
				n_ids = int'(it.max_handlers);
			if (RESULT_LIMIT < n_ids)
				n_ids = RESULT_LIMIT;
			if (n_ids > longest_dispatch)
				longest_dispatch = n_ids;
			for (int k = 0; k < n_ids; k++) begin
				r.has_handler = 1'b1;
				r.handler_out = hook_owner[order[k]];
				r.dispatch_count = CAP_W'(n_ids);
				r.entries_used = CAP_W'(hook_used);
				r.last = (k == n_ids - 1);
				due_q.push_back(r);
			end
			if (n_ids > 0)
				return;
		end
		default: ;
		endcase
		r.entries_used = CAP_W'(hook_used);
		due_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [CODE_W-1:0] exp_val,
			input logic [CODE_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q.delete();
			hook_used = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					$error("result item with none expected: handler_out %0h",
						out_item.handler_out);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					check_field("status", CODE_W'(want.status), CODE_W'(out_item.status));
					check_field("has_handler", CODE_W'(want.has_handler),
						CODE_W'(out_item.has_handler));
					check_field("handler_out", want.handler_out, out_item.handler_out);
					check_field("dispatch_count", CODE_W'(want.dispatch_count),
						CODE_W'(out_item.dispatch_count));
					check_field("entries_used", CODE_W'(want.entries_used),
						CODE_W'(out_item.entries_used));
					check_field("last", CODE_W'(want.last), CODE_W'(out_item.last));
					results_checked++;
				end
			end
			if (in_valid && in_ready)
				apply_item(in_item);
			pending <= due_q.size();
		end
	end

endmodule

FILE: dv/priority_event_hook_table_top_tb.sv
// Testbench top for the priority event hook table: clock, reset, item stimulus
// with random gaps and receiver stalls, and the verdict.
// Depends on phet_pkg, hook_table_checker and the block's RTL.
module priority_event_hook_table_top_tb;
	import phet_pkg::*;

	localparam int          CLK_PERIOD   = 12;
	localparam logic [1:0]  FUNC_SPARE   = 2'd3;
	localparam logic [15:0] HOT_CODE     = 16'hFFFF;
	localparam int          RANDOM_ITEMS = 305;
	localparam int          HOLD_CYCLES  = 2000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	int fail_count;
	int pending;
	int results_checked;
	int longest_dispatch;
	int n_reg;
	int n_disp;
	int n_en;
	int n_spare;
	bit tx_burst;
	bit rx_burst;
	bit rx_hold_req;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	priority_event_hook_table_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	hook_table_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.longest_dispatch(longest_dispatch)
	);

	function automatic in_item_t op(logic [1:0] f, logic [15:0] ev, logic [15:0] hid,
			logic signed [15:0] pr, logic en, logic [5:0] cap);
		in_item_t it;
		it.func = f;
		it.event_code = ev;
		it.owner_id = hid;
		it.priority_req = pr;
		it.enable_flag = en;
		it.max_handlers = cap;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.func = 2'($urandom_range(0, 3));
		it.event_code = CODE_W'($urandom);
		it.owner_id = CODE_W'($urandom);
		it.priority_req = CODE_W'($urandom);
		it.enable_flag = 1'($urandom);
		it.max_handlers = CAP_W'($urandom);
		return it;
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return HOT_CODE;
		if (roll < 80)
			return 16'h0000;
		if (roll < 85)
			return 16'h1234;
		return CODE_W'($urandom);
	endfunction

	function automatic logic [CODE_W-1:0] pick_handler();
		if ($urandom_range(0, 99) >= 60)
			return CODE_W'($urandom);
		case ($urandom_range(0, 4))
		0: return 16'h0000;
		1: return 16'h0001;
		2: return 16'h0002;
		3: return 16'h0003;
		default: return 16'hFFFF;
		endcase
	endfunction

	// few distinct priorities make ties common
	function automatic logic signed [CODE_W-1:0] pick_prio();
		if ($urandom_range(0, 99) >= 50)
			return CODE_W'($urandom);
		case ($urandom_range(0, 4))
		0: return 16'sh8000;
		1: return -16'sd1;
		2: return 16'sd0;
		3: return 16'sd1;
		default: return 16'sh7FFF;
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_item(input in_item_t it);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		case (it.func)
		FUNC_REGISTER: n_reg++;
		FUNC_DISPATCH: n_disp++;
		FUNC_ENABLE: n_en++;
		default: n_spare++;
		endcase
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = rx_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		in_item_t plan[$];
		in_item_t it;
		int       sel;
		bit       table_full;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		rx_hold_req = 1'b0;
		n_reg = 0;
		n_disp = 0;
		n_en = 0;
		n_spare = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then a few hooks with extreme codes, ids and priorities
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'h0000, 16'sd0, 1'b0, 6'd32));
		plan.push_back(op(FUNC_ENABLE, 16'h0000, 16'hFFFF, 16'sd0, 1'b0, 6'd0));
		plan.push_back(op(FUNC_SPARE, 16'hFFFF, 16'hFFFF, -16'sd1, 1'b1, 6'd63));
		plan.push_back(op(FUNC_REGISTER, HOT_CODE, 16'h0000, 16'sh8000, 1'b0, 6'd0));
		plan.push_back(op(FUNC_REGISTER, HOT_CODE, 16'hFFFF, 16'sh7FFF, 1'b1, 6'd63));
		plan.push_back(op(FUNC_REGISTER, HOT_CODE, 16'h0001, 16'sh7FFF, 1'b0, 6'd0));
		plan.push_back(op(FUNC_REGISTER, 16'h0000, 16'h0002, 16'sd0, 1'b0, 6'd0));
		plan.push_back(op(FUNC_REGISTER, HOT_CODE, 16'h0003, -16'sd1, 1'b1, 6'd1));
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'h0000, 16'sd0, 1'b0, 6'd0));
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'h0000, 16'sd0, 1'b0, 6'd1));
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'hFFFF, 16'sh7FFF, 1'b1, 6'd63));
		plan.push_back(op(FUNC_DISPATCH, 16'h0000, 16'h0000, 16'sd0, 1'b0, 6'd32));
		plan.push_back(op(FUNC_DISPATCH, 16'h1234, 16'h0000, 16'sd0, 1'b0, 6'd32));
		plan.push_back(op(FUNC_ENABLE, 16'h0000, 16'hFFFF, 16'sd0, 1'b0, 6'd0));
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'h0000, 16'sd0, 1'b0, 6'd32));
		plan.push_back(op(FUNC_ENABLE, 16'h0000, 16'h0002, 16'sd0, 1'b0, 6'd0));
		plan.push_back(op(FUNC_DISPATCH, 16'h0000, 16'h0000, 16'sd0, 1'b0, 6'd32));
		plan.push_back(op(FUNC_ENABLE, 16'hFFFF, 16'h0002, 16'sd0, 1'b1, 6'd63));
		plan.push_back(op(FUNC_ENABLE, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b1, 6'd63));
		plan.push_back(op(FUNC_DISPATCH, HOT_CODE, 16'h0000, 16'sd0, 1'b0, 6'd4));
		plan.push_back(op(FUNC_SPARE, 16'h0000, 16'h0000, 16'sd0, 1'b0, 6'd0));
		foreach (plan[k])
			send_item(plan[k]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			tx_burst = (i >= 40 && i < 80);
			rx_burst = (i >= 40 && i < 80);
			// long receiver hold-off while items keep coming
			if (i == 120)
				rx_hold_req = 1'b1;
			if (i == 200) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			table_full = (n_reg >= dut.TABLE_DEPTH);
			sel = $urandom_range(0, 99);
			it = noise_item();
			if (table_full ? sel < 8 : sel < 40) begin
				it.func = FUNC_REGISTER;
				it.event_code = ($urandom_range(0, 99) < 85) ? HOT_CODE : pick_code();
				it.owner_id = pick_handler();
				it.priority_req = pick_prio();
			end else if (table_full ? sel < 60 : sel < 75) begin
				it.func = FUNC_DISPATCH;
				it.event_code = pick_code();
				if ($urandom_range(0, 99) < 40)
					it.max_handlers = $urandom_range(0, 1) ? 6'd32 : 6'd63;
			end else if (table_full ? sel < 92 : sel < 95) begin
				it.func = FUNC_ENABLE;
				it.owner_id = pick_handler();
				it.enable_flag = ($urandom_range(0, 99) < 60);
			end else begin
				it.func = FUNC_SPARE;
			end
			send_item(it);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		$display("tb: %0d items sent: %0d register, %0d dispatch, %0d enable, %0d unused code",
			n_reg + n_disp + n_en + n_spare, n_reg, n_disp, n_en, n_spare);
		$display("tb: %0d result items checked, longest dispatch gave %0d ids",
			results_checked, longest_dispatch);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * 64'd4_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule
